FILE: design/des_ks_pkg.sv
package des_ks_pkg;

  localparam int unsigned HalfBits   = 28;
  localparam int unsigned Rounds     = 16;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned CdBits     = 56;
  localparam int unsigned SubkeyBits = 48;
  localparam int unsigned RoundBits  = 4;

  // One bit per round, set where both halves rotate by two
  localparam logic [Rounds-1:0] ROT_TWO = 16'h7EFC;

  localparam logic [6:0] PC1_TAB [CdBits] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [SubkeyBits] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  typedef struct packed {
    logic                valid;
    logic [HalfBits-1:0] c;
    logic [HalfBits-1:0] d;
  } ks_link_t;

  function automatic logic [CdBits-1:0] pc1(input logic [KeyBits-1:0] key);
    logic [CdBits-1:0] r;
    r = '0;
    for (int i = 0; i < CdBits; i++) begin
      r[6'(CdBits - 1 - i)] = key[6'(KeyBits - int'(PC1_TAB[i]))];
    end
    return r;
  endfunction

  function automatic logic [SubkeyBits-1:0] pc2(input logic [CdBits-1:0] cd);
    logic [SubkeyBits-1:0] r;
    r = '0;
    for (int i = 0; i < SubkeyBits; i++) begin
      r[6'(SubkeyBits - 1 - i)] = cd[6'(CdBits - int'(PC2_TAB[i]))];
    end
    return r;
  endfunction

  function automatic logic [HalfBits-1:0] rot28(input logic [HalfBits-1:0] x,
                                                input logic two);
    logic [HalfBits-1:0] r;
    r = two ? {x[HalfBits-3:0], x[HalfBits-1:HalfBits-2]}
            : {x[HalfBits-2:0], x[HalfBits-1]};
    return r;
  endfunction

endpackage

FILE: design/des_ks_cell.sv
module des_ks_cell import des_ks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  shift_two_i,
  input  ks_link_t              link_i,
  output ks_link_t              link_o,
  output logic [SubkeyBits-1:0] subkey_o
);

  logic                valid_q;
  logic [HalfBits-1:0] c_q, c_d;
  logic [HalfBits-1:0] d_q, d_d;

  assign c_d = rot28(link_i.c, shift_two_i);
  assign d_d = rot28(link_i.d, shift_two_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      d_q <= d_d;
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.c     = c_q;
  assign link_o.d     = d_q;

  // Mask so the top level can merge all cells with an OR
  assign subkey_o = valid_q ? pc2({c_q, d_q}) : '0;

endmodule

FILE: design/des_key_schedule.sv
// The first subkey of a key passes through the first round cell's register and then the output register.
// One subkey per cycle while the output is not stalled; a new key is held off while the
//   16-cell round chain is busy, and enters as the last round leaves.
// Output stalls hold the whole chain, but a key can still enter the first cell while the chain is empty.
// Reset (rst_ni, asynchronous, active low) empties the chain and the output register.
module des_key_schedule import des_ks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KeyBits-1:0]    key_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SubkeyBits-1:0] subkey_o,
  output logic [RoundBits-1:0]  round_index_o,
  output logic                  last_round_o
);

  ks_link_t              head;
  ks_link_t              link [Rounds];
  logic [SubkeyBits-1:0] sub  [Rounds];
  logic [CdBits-1:0]     cd_in;
  logic                  busy;
  logic                  adv;
  logic                  accept;

  logic                  out_valid_q;
  logic [SubkeyBits-1:0] subkey_q, subkey_d;
  logic [RoundBits-1:0]  index_q, index_d;
  logic                  last_q;

  assign cd_in      = pc1(key_word_i);
  assign head.valid = accept;
  assign head.c     = cd_in[CdBits-1:HalfBits];
  assign head.d     = cd_in[HalfBits-1:0];

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy && !(link[Rounds-1].valid && adv);
  assign accept     = in_valid_i && !in_stall_o;

  for (genvar k = 0; k < Rounds; k++) begin : g_round
    if (k == 0) begin : g_first
      des_ks_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .en_i        (adv || accept),
        .shift_two_i (ROT_TWO[k]),
        .link_i      (head),
        .link_o      (link[k]),
        .subkey_o    (sub[k])
      );
    end else begin : g_next
      des_ks_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .en_i        (adv),
        .shift_two_i (ROT_TWO[k]),
        .link_i      (link[k-1]),
        .link_o      (link[k]),
        .subkey_o    (sub[k])
      );
    end
  end

  always_comb begin
    busy     = 1'b0;
    subkey_d = '0;
    index_d  = '0;
    for (int k = 0; k < Rounds; k++) begin
      busy     = busy | link[k].valid;
      subkey_d = subkey_d | sub[k];
      index_d  = index_d | (link[k].valid ? RoundBits'(k) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      subkey_q <= subkey_d;
      index_q  <= index_d;
      last_q   <= link[Rounds-1].valid;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign subkey_o      = subkey_q;
  assign round_index_o = index_q;
  assign last_round_o  = last_q;

endmodule

FILE: design/des_ks_chk.sv
module des_ks_chk import des_ks_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [KeyBits-1:0]    key_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SubkeyBits-1:0] subkey_o,
  input logic [RoundBits-1:0]  round_index_o,
  input logic                  last_round_o
);

  localparam logic [RoundBits-1:0] LastIdx = RoundBits'(Rounds - 1);
  localparam logic [RoundBits-1:0] NearIdx = RoundBits'(Rounds - 2);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(subkey_o)
                                   && $stable(round_index_o))
    else $error("stalled subkey changed");

  a_round_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_round_o
      |=> out_valid_o && round_index_o == $past(round_index_o) + 4'd1)
    else $error("subkey rounds not contiguous");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_round_o == (round_index_o == LastIdx)))
    else $error("last flag off the sixteenth round");

  a_key_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && round_index_o < NearIdx |-> in_stall_o)
    else $error("key taken before previous key drained");

endmodule

bind des_key_schedule des_ks_chk u_chk (.*);
